// ===== src/cciob_pkg.sv =====
package cciob_pkg;

	localparam int BANK_COUNT_DEF = 32;
	localparam int ROM_BYTES_DEF  = 2048;
	localparam int BANK_BYTES     = 65536;
	localparam int ADDR_W         = $clog2(BANK_BYTES);
	localparam int BANK_W         = 5;
	localparam int PHYS_W         = ADDR_W + BANK_W;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;

	localparam logic [15:0] IDLE_LIMIT_RST  = 16'd64;
	localparam logic [7:0]  LAST_STATUS_RST = 8'hFF;
	localparam logic [7:0]  UNUSED_PORT_VAL = 8'hFF;
	localparam logic [15:0] COMMON_BASE     = 16'h8000;

	typedef enum logic [1:0] {
		FUNC_IO_RD  = 2'd0,
		FUNC_IO_WR  = 2'd1,
		FUNC_MEM_RD = 2'd2,
		FUNC_MEM_WR = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		GRP_OUT_LATCH = 3'd0,
		GRP_IN_LATCH  = 3'd1,
		GRP_STATUS    = 3'd2,
		GRP_ROM_CTRL  = 3'd3,
		GRP_BANK      = 3'd6
	} port_grp_t;

	typedef enum logic [1:0] {
		TGT_RAM     = 2'd0,
		TGT_ROM     = 2'd1,
		TGT_DISCARD = 2'd2
	} mem_target_t;

	typedef struct packed {
		logic [7:0]  latch_data;
		logic [7:0]  latch_seq;
		logic        pending_out;
		logic        pending_in;
		logic [15:0] address;
		logic [7:0]  write_value;
		logic [7:0]  port;
	} req_t;

	typedef struct packed {
		logic              idle_stop;
		logic [1:0]        mem_target;
		logic [PHYS_W-1:0] phys_address;
		logic [7:0]        send_data;
		logic              send_valid;
		logic [7:0]        ack_seq;
		logic              ack_valid;
		logic [7:0]        read_data;
	} rsp_t;

endpackage

// ===== src/coprocessor_card_io_bank_map.sv =====
// An accepted request passes the input register, then the response register, to the master side.
// Throughput: one request per cycle; the input register and the response register
// advance together whenever the response register is empty or being taken.
// Reset: arst_n clears the valid flags and the card state (ROM shadowing on, bank 0,
// status history 0xFF, poll streak 0) and sets the idle limit to 64.
module coprocessor_card_io_bank_map
	import cciob_pkg::*;
#(
	parameter int BANK_COUNT = BANK_COUNT_DEF,
	parameter int ROM_BYTES  = ROM_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [15:0]           cfg_data,    // idle_limit
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// port, write_value, address, pending_in, pending_out, latch_seq, latch_data
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,     // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// read_data, ack_valid, ack_seq, send_valid, send_data, phys_address,
	// mem_target, idle_stop
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int ROM_LOG = $clog2(ROM_BYTES);
	localparam int SHIFT   = 15 + ROM_LOG;
	localparam longint unsigned ROM_MUL =
		((64'd1 << SHIFT) + longint'(ROM_BYTES) - 64'd1) / longint'(ROM_BYTES);
	localparam int QUOT_W  = 16 - ROM_LOG;
	localparam int PROD_W  = SHIFT + QUOT_W;
	localparam int WRAP_STEPS = (32 + BANK_COUNT - 1) / BANK_COUNT - 1;
	localparam logic [BANK_W:0] BANK_LIM = (BANK_W + 1)'(BANK_COUNT);

	function automatic logic [BANK_W-1:0] bank_wrap(input logic [BANK_W-1:0] b);
		logic [BANK_W:0] v;
		v = {1'b0, b};
		for (int i = 0; i < WRAP_STEPS; i++) begin
			if (v >= BANK_LIM) begin
				v = v - BANK_LIM;
			end
		end
		return v[BANK_W-1:0];
	endfunction

	req_t                req_in;
	logic [PROD_W-1:0]   rom_prod;

	logic                valid_s1;
	req_t                req_s1;
	func_t               func_s1;
	logic [QUOT_W-1:0]   quot_s1;

	logic                valid_s2;
	rsp_t                rsp_s2;

	logic [15:0]         idle_limit_q;
	logic                rom_shadow_q;
	logic [7:0]          bank_q;
	logic [7:0]          out_latch_q;
	logic [7:0]          last_status_q;
	logic [15:0]         poll_streak_q;
	logic                blocked_q;

	logic                adv;
	rsp_t                rsp;
	logic [2:0]          grp;
	logic [7:0]          status;
	logic [15:0]         streak_inc;
	logic [BANK_W-1:0]   bank;
	logic [14:0]         rom_base;
	logic [14:0]         rom_off;
	logic                low_half;

	logic                rom_shadow_d;
	logic [7:0]          bank_d;
	logic [7:0]          out_latch_d;
	logic [7:0]          last_status_d;
	logic [15:0]         poll_streak_d;
	logic                blocked_d;

	assign cfg_ready = 1'b1;
	assign req_in    = req_t'(s_tdata[$bits(req_t)-1:0]);
	assign rom_prod  = PROD_W'(req_in.address[14:0]) * PROD_W'(ROM_MUL);

	assign adv      = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1  <= req_in;
			func_s1 <= func_t'(s_tuser);
			quot_s1 <= rom_prod[SHIFT +: QUOT_W];
		end
	end

	always_comb begin
		rsp           = '0;
		grp           = req_s1.port[7:5];
		status        = {req_s1.pending_in, 6'b0, req_s1.pending_out};
		streak_inc    = poll_streak_q + 16'd1;
		bank          = bank_wrap(bank_q[5:1]);
		rom_base      = 15'(32'(quot_s1) * ROM_BYTES);
		rom_off       = req_s1.address[14:0] - rom_base;
		low_half      = req_s1.address < COMMON_BASE;
		rom_shadow_d  = rom_shadow_q;
		bank_d        = bank_q;
		out_latch_d   = out_latch_q;
		last_status_d = last_status_q;
		poll_streak_d = poll_streak_q;
		blocked_d     = blocked_q;

		unique case (func_s1) inside
			FUNC_IO_RD: begin
				case (grp)
					GRP_OUT_LATCH: rsp.read_data = out_latch_q;
					GRP_IN_LATCH: begin
						rsp.ack_valid = req_s1.pending_in;
						rsp.ack_seq   = req_s1.pending_in ? req_s1.latch_seq : 8'd0;
						rsp.read_data = req_s1.latch_data;
						poll_streak_d = '0;
					end
					GRP_STATUS: begin
						rsp.read_data = status;
						if (status == last_status_q) begin
							if (streak_inc >= idle_limit_q) begin
								rsp.idle_stop = 1'b1;
								blocked_d     = 1'b1;
								poll_streak_d = '0;
							end else begin
								poll_streak_d = streak_inc;
							end
						end else begin
							last_status_d = status;
							poll_streak_d = '0;
						end
					end
					default: rsp.read_data = UNUSED_PORT_VAL;
				endcase
			end
			FUNC_IO_WR: begin
				case (grp)
					GRP_OUT_LATCH: begin
						out_latch_d    = req_s1.write_value;
						rsp.send_valid = 1'b1;
						rsp.send_data  = req_s1.write_value;
						poll_streak_d  = '0;
					end
					GRP_ROM_CTRL: rom_shadow_d = req_s1.write_value[0];
					GRP_BANK:     bank_d       = req_s1.write_value;
					default: ;
				endcase
			end
			FUNC_MEM_RD, FUNC_MEM_WR: begin
				if (rom_shadow_q && low_half) begin
					if (func_s1 == FUNC_MEM_WR) begin
						rsp.mem_target = TGT_DISCARD;
					end else begin
						rsp.mem_target   = TGT_ROM;
						rsp.phys_address = PHYS_W'(rom_off);
					end
				end else if (bank_q[6] && !low_half) begin
					rsp.mem_target   = TGT_RAM;
					rsp.phys_address = PHYS_W'(req_s1.address);
				end else begin
					rsp.mem_target   = TGT_RAM;
					rsp.phys_address = {bank, req_s1.address};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			idle_limit_q  <= IDLE_LIMIT_RST;
			rom_shadow_q  <= 1'b1;
			bank_q        <= '0;
			out_latch_q   <= '0;
			last_status_q <= LAST_STATUS_RST;
			poll_streak_q <= '0;
			blocked_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				idle_limit_q <= cfg_data;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (adv && valid_s1) begin
				rom_shadow_q  <= rom_shadow_d;
				bank_q        <= bank_d;
				out_latch_q   <= out_latch_d;
				last_status_q <= last_status_d;
				poll_streak_q <= poll_streak_d;
				blocked_q     <= blocked_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_tvalid = valid_s2 && !(blocked_q && 1'b0);
	assign m_tdata  = OUT_DATA_W'(rsp_s2);

endmodule

// ===== test/coprocessor_card_io_bank_map_tb.sv =====
`timescale 1ns / 100ps

module coprocessor_card_io_bank_map_tb;
	import cciob_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 315;
	localparam logic [15:0] PHASE_LIMIT [PHASES] = '{16'd1, 16'd0, 16'hFFFF, 16'd5, 16'd64, 16'd3};
	localparam int PHASE_SND_IDLE [PHASES] = '{11, 11, 69, 69, 0, 0};
	localparam int PHASE_RCV_IDLE [PHASES] = '{69, 69, 11, 11, 0, 0};

	typedef struct {
		func_t fn;
		req_t  rq;
		bit    fixed;
		rsp_t  want;
	} access_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [15:0]           cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [1:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	bit          shadow_on;
	logic [7:0]  bank_sel;
	logic [7:0]  latch_out;
	logic [7:0]  status_seen;
	logic [15:0] streak;
	logic [15:0] limit_now;

	rsp_t        awaited_rsp[$];
	access_row_t access_tab[$];
	int          mismatches = 0;
	int          snd_idle = 0;
	int          rcv_idle = 0;
	int          hold_left = 0;
	bit          poll_pin = 1'b0;
	bit          poll_pout = 1'b0;

	coprocessor_card_io_bank_map i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic req_t bus_req(logic [7:0] port, logic [7:0] wval, logic [15:0] addr,
			bit pin, bit pout, logic [7:0] seq, logic [7:0] ldata);
		req_t r;
		r.port        = port;
		r.write_value = wval;
		r.address     = addr;
		r.pending_in  = pin;
		r.pending_out = pout;
		r.latch_seq   = seq;
		r.latch_data  = ldata;
		return r;
	endfunction

	function automatic rsp_t bus_rsp(logic [7:0] rd, bit ackv, logic [7:0] acks, bit sndv,
			logic [7:0] sndd, logic [PHYS_W-1:0] phys, mem_target_t tgt, bit stop);
		rsp_t r;
		r.read_data    = rd;
		r.ack_valid    = ackv;
		r.ack_seq      = acks;
		r.send_valid   = sndv;
		r.send_data    = sndd;
		r.phys_address = phys;
		r.mem_target   = tgt;
		r.idle_stop    = stop;
		return r;
	endfunction

	function automatic rsp_t predict_access(func_t fn, req_t rq);
		rsp_t        o;
		logic [2:0]  grp;
		logic [7:0]  st;
		int          bank;
		o = '0;
		grp = rq.port[7:5];
		case (fn)
			FUNC_IO_RD: begin
				case (grp)
					GRP_OUT_LATCH: o.read_data = latch_out;
					GRP_IN_LATCH: begin
						if (rq.pending_in) begin
							o.ack_valid = 1'b1;
							o.ack_seq   = rq.latch_seq;
						end
						streak = '0;
						o.read_data = rq.latch_data;
					end
					GRP_STATUS: begin
						st = {rq.pending_in, 6'd0, rq.pending_out};
						if (st == status_seen) begin
							streak = streak + 16'd1;
							if (streak >= limit_now) begin
								o.idle_stop = 1'b1;
								streak = '0;
							end
						end else begin
							status_seen = st;
							streak = '0;
						end
						o.read_data = st;
					end
					default: o.read_data = UNUSED_PORT_VAL;
				endcase
			end
			FUNC_IO_WR: begin
				case (grp)
					GRP_OUT_LATCH: begin
						latch_out    = rq.write_value;
						o.send_valid = 1'b1;
						o.send_data  = rq.write_value;
						streak = '0;
					end
					GRP_ROM_CTRL: shadow_on = rq.write_value[0];
					GRP_BANK: bank_sel = rq.write_value;
					default: ;
				endcase
			end
			default: begin
				bank = int'(bank_sel[5:1]) % BANK_COUNT_DEF;
				if (shadow_on && rq.address < COMMON_BASE) begin
					if (fn == FUNC_MEM_WR) begin
						o.mem_target = TGT_DISCARD;
					end else begin
						o.mem_target   = TGT_ROM;
						o.phys_address = PHYS_W'(int'(rq.address) % ROM_BYTES_DEF);
					end
				end else if (bank_sel[6] && rq.address >= COMMON_BASE) begin
					o.mem_target   = TGT_RAM;
					o.phys_address = PHYS_W'(rq.address);
				end else begin
					o.mem_target   = TGT_RAM;
					o.phys_address = PHYS_W'(bank * BANK_BYTES + int'(rq.address));
				end
			end
		endcase
		return o;
	endfunction

	function automatic void random_access(output func_t fn, output req_t rq);
		logic [63:0] raw;
		int          pick;
		raw = {$urandom, $urandom};
		rq = raw[$bits(req_t)-1:0];
		fn = func_t'($urandom_range(3));
		pick = $urandom_range(99);
		if ($urandom_range(99) < 4) begin
			poll_pin  = $urandom_range(1);
			poll_pout = $urandom_range(1);
		end
		if (pick < 45) begin
			fn = FUNC_IO_RD;
			rq.port[7:5]   = GRP_STATUS;
			rq.pending_in  = poll_pin;
			rq.pending_out = poll_pout;
		end else if (pick < 55) begin
			fn = FUNC_IO_WR;
			rq.port[7:5] = (pick < 50) ? GRP_ROM_CTRL : GRP_BANK;
		end
	endfunction

	task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
		mismatches++;
		if (mismatches <= 200)
			$display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
	endtask

	task automatic send_access(func_t fn, req_t rq, bit fixed, rsp_t want);
		rsp_t calc;
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		calc = predict_access(fn, rq);
		awaited_rsp.push_back(fixed ? want : calc);
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= IN_DATA_W'(rq);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_responses();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (awaited_rsp.size() != 0);
	endtask

	task automatic write_idle_limit(logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = value;
	endtask

	task automatic check_response(logic [OUT_DATA_W-1:0] raw);
		rsp_t got;
		rsp_t want;
		if (awaited_rsp.size() == 0) begin
			note_mismatch("unexpected response", raw, 0);
			return;
		end
		got  = raw[$bits(rsp_t)-1:0];
		want = awaited_rsp.pop_front();
		if (got.read_data !== want.read_data)
			note_mismatch("read_data", got.read_data, want.read_data);
		if (got.ack_valid !== want.ack_valid)
			note_mismatch("ack_valid", got.ack_valid, want.ack_valid);
		if (got.ack_seq !== want.ack_seq)
			note_mismatch("ack_seq", got.ack_seq, want.ack_seq);
		if (got.send_valid !== want.send_valid)
			note_mismatch("send_valid", got.send_valid, want.send_valid);
		if (got.send_data !== want.send_data)
			note_mismatch("send_data", got.send_data, want.send_data);
		if (got.phys_address !== want.phys_address)
			note_mismatch("phys_address", got.phys_address, want.phys_address);
		if (got.mem_target !== want.mem_target)
			note_mismatch("mem_target", got.mem_target, want.mem_target);
		if (got.idle_stop !== want.idle_stop)
			note_mismatch("idle_stop", got.idle_stop, want.idle_stop);
		if (raw[OUT_DATA_W-1:$bits(rsp_t)] !== '0)
			note_mismatch("tdata padding", raw[OUT_DATA_W-1:$bits(rsp_t)], 0);
	endtask

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				check_response(m_tdata);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rcv_idle);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		func_t fn;
		req_t  rq;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_IO_RD;

		shadow_on   = 1'b1;
		bank_sel    = '0;
		latch_out   = '0;
		status_seen = LAST_STATUS_RST;
		streak      = '0;
		limit_now   = IDLE_LIMIT_RST;

		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h00, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'hFF, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'hFF, 0, 8'h00, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h60, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'hFF, 0, 8'h00, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h20, 8'h00, 16'h0000, 1, 0, 8'hFF, 8'hA5),
			1, bus_rsp(8'hA5, 1, 8'hFF, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h3F, 8'h00, 16'h0000, 0, 0, 8'h33, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h40, 8'h00, 16'h0000, 1, 1, 8'h00, 8'h00),
			1, bus_rsp(8'h81, 0, 8'h00, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h5F, 8'h00, 16'h0000, 1, 1, 8'h00, 8'h00),
			0, '0});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h40, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_WR, bus_req(8'h1F, 8'hFF, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 1, 8'hFF, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_RD, bus_req(8'h00, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'hFF, 0, 8'h00, 0, 8'h00, 0, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_MEM_RD, bus_req(8'h00, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 0, TGT_ROM, 0)});
		access_tab.push_back('{FUNC_MEM_RD, bus_req(8'h00, 8'h00, 16'h7FFF, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 21'h0007FF, TGT_ROM, 0)});
		access_tab.push_back('{FUNC_MEM_WR, bus_req(8'h00, 8'h00, 16'h7FFF, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 0, TGT_DISCARD, 0)});
		access_tab.push_back('{FUNC_MEM_RD, bus_req(8'h00, 8'h00, 16'h8000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 21'h008000, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_MEM_WR, bus_req(8'h00, 8'h00, 16'hFFFF, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 21'h00FFFF, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_WR, bus_req(8'h60, 8'hFE, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, '0});
		access_tab.push_back('{FUNC_IO_WR, bus_req(8'hC0, 8'hFF, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, '0});
		access_tab.push_back('{FUNC_MEM_RD, bus_req(8'h00, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			0, '0});
		access_tab.push_back('{FUNC_MEM_WR, bus_req(8'h00, 8'h00, 16'hFFFF, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 21'h00FFFF, TGT_RAM, 0)});
		access_tab.push_back('{FUNC_IO_WR, bus_req(8'hDF, 8'h3E, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, '0});
		access_tab.push_back('{FUNC_MEM_RD, bus_req(8'h00, 8'h00, 16'hFFFF, 0, 0, 8'h00, 8'h00),
			0, '0});
		access_tab.push_back('{FUNC_IO_WR, bus_req(8'hE0, 8'h55, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, '0});
		access_tab.push_back('{FUNC_IO_WR, bus_req(8'h20, 8'hAA, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, '0});
		access_tab.push_back('{FUNC_IO_WR, bus_req(8'h7F, 8'h01, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, '0});
		access_tab.push_back('{FUNC_MEM_WR, bus_req(8'h00, 8'h00, 16'h0000, 0, 0, 8'h00, 8'h00),
			1, bus_rsp(8'h00, 0, 8'h00, 0, 8'h00, 0, TGT_DISCARD, 0)});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		snd_idle = 11;
		rcv_idle = 69;
		foreach (access_tab[i])
			send_access(access_tab[i].fn, access_tab[i].rq, access_tab[i].fixed,
				access_tab[i].want);
		drain_responses();

		for (int p = 0; p < PHASES; p++) begin
			write_idle_limit(PHASE_LIMIT[p]);
			snd_idle = PHASE_SND_IDLE[p];
			rcv_idle = PHASE_RCV_IDLE[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the response side so the pipeline backs up
				if (p == 4 && i == 100)
					hold_left = 300;
				if (p == 5 && i == 150)
					drain_responses();
				random_access(fn, rq);
				send_access(fn, rq, 1'b0, '0);
			end
			drain_responses();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== coprocessor_card_io_bank_map.f =====
src/cciob_pkg.sv
src/coprocessor_card_io_bank_map.sv
test/coprocessor_card_io_bank_map_tb.sv
